>>> rtl/lion_pkg.sv
package lion_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 24;

    localparam int LR_W      = 24;
    localparam int BETA_W    = 17;
    localparam int WD_W      = 16;
    localparam int BETA_FRAC = 16;
    localparam int BETA_ONE  = 65536;

    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 4;

    typedef enum logic [1:0] {
        REG_LEARNING_RATE = 2'd0,
        REG_FIRST_BETA    = 2'd1,
        REG_SECOND_BETA   = 2'd2,
        REG_DECAY_RATE    = 2'd3
    } t_reg;

    typedef struct packed {
        logic [LR_W-1:0]   learning_rate;
        logic [BETA_W-1:0] first_beta;
        logic [BETA_W-1:0] second_beta;
        logic [WD_W-1:0]   decay_rate;
    } t_cfg;

    function automatic logic [BETA_W-1:0] clamp_beta(input logic [BETA_W-1:0] b);
        logic [BETA_W-1:0] one;
        one = BETA_W'(BETA_ONE);
        return (b > one) ? one : b;
    endfunction

endpackage

>>> rtl/lion_optimizer_update.sv
// Lion optimizer update, one element per item. The block takes a new item on
// every clock (busy is always low) and delivers its result through seven
// register stages of the datapath: products, sign and momentum sums, the
// decayed update term, the two learning-rate partial products, their
// recombination and rounding, and the final add with saturation. o_valid is
// high for exactly one cycle per result and the receiver cannot stall the
// block, so it must take every result in the cycle it is shown. The user must
// write configuration registers through the APB port only while no item is in
// flight; the block itself does not enforce this.
module lion_optimizer_update #(
    parameter int DATA_WIDTH = lion_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = lion_pkg::FRAC_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic signed [DATA_WIDTH-1:0]     i_weight_in,
    input  logic signed [DATA_WIDTH-1:0]     i_gradient,
    input  logic signed [DATA_WIDTH-1:0]     i_momentum_in,
    output logic                             o_valid,
    output logic signed [DATA_WIDTH-1:0]     o_weight_out,
    output logic signed [DATA_WIDTH-1:0]     o_momentum_out,
    output logic                             o_saturated,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [lion_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [lion_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [lion_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready
);

    lion_pkg::t_cfg                            w_cfg;
    logic                                      w_mix_valid;
    logic signed [DATA_WIDTH-1:0]              w_mix_weight;
    logic signed [DATA_WIDTH-1:0]              w_mix_momentum;
    logic signed [DATA_WIDTH+lion_pkg::WD_W:0] w_mix_wdp;
    logic                                      w_mix_pos;
    logic                                      w_mix_neg;

    assign busy = 1'b0;

    lion_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    lion_mix #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_mix (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (start && !busy),
        .i_weight   (i_weight_in),
        .i_gradient (i_gradient),
        .i_momentum (i_momentum_in),
        .i_cfg      (w_cfg),
        .o_valid    (w_mix_valid),
        .o_weight   (w_mix_weight),
        .o_momentum (w_mix_momentum),
        .o_wdp      (w_mix_wdp),
        .o_pos      (w_mix_pos),
        .o_neg      (w_mix_neg)
    );

    lion_step #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_step (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (w_mix_valid),
        .i_weight       (w_mix_weight),
        .i_momentum     (w_mix_momentum),
        .i_wdp          (w_mix_wdp),
        .i_pos          (w_mix_pos),
        .i_neg          (w_mix_neg),
        .i_lr           (w_cfg.learning_rate),
        .o_valid        (o_valid),
        .o_weight_out   (o_weight_out),
        .o_momentum_out (o_momentum_out),
        .o_saturated    (o_saturated)
    );

endmodule

>>> rtl/lion_cfg.sv
module lion_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [lion_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [lion_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [lion_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    output lion_pkg::t_cfg                      o_cfg
);

    lion_pkg::t_cfg r_cfg;
    lion_pkg::t_cfg n_cfg;
    lion_pkg::t_reg w_sel;
    logic           w_wr;

    assign w_sel  = lion_pkg::t_reg'(paddr[lion_pkg::APB_ADDR_W-1:2]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (w_wr) begin
            unique case (w_sel)
                lion_pkg::REG_LEARNING_RATE:
                    n_cfg.learning_rate = pwdata[lion_pkg::LR_W-1:0];
                lion_pkg::REG_FIRST_BETA:
                    n_cfg.first_beta = pwdata[lion_pkg::BETA_W-1:0];
                lion_pkg::REG_SECOND_BETA:
                    n_cfg.second_beta = pwdata[lion_pkg::BETA_W-1:0];
                lion_pkg::REG_DECAY_RATE:
                    n_cfg.decay_rate = pwdata[lion_pkg::WD_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (w_sel)
            lion_pkg::REG_LEARNING_RATE:
                prdata = lion_pkg::APB_DATA_W'(r_cfg.learning_rate);
            lion_pkg::REG_FIRST_BETA:
                prdata = lion_pkg::APB_DATA_W'(r_cfg.first_beta);
            lion_pkg::REG_SECOND_BETA:
                prdata = lion_pkg::APB_DATA_W'(r_cfg.second_beta);
            lion_pkg::REG_DECAY_RATE:
                prdata = lion_pkg::APB_DATA_W'(r_cfg.decay_rate);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.learning_rate <= lion_pkg::LR_W'(1678);
            r_cfg.first_beta    <= lion_pkg::BETA_W'(58982);
            r_cfg.second_beta   <= lion_pkg::BETA_W'(64881);
            r_cfg.decay_rate    <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

>>> rtl/lion_mix.sv
module lion_mix #(
    parameter int DATA_WIDTH = lion_pkg::DATA_WIDTH_DEF
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_valid,
    input  logic signed [DATA_WIDTH-1:0]              i_weight,
    input  logic signed [DATA_WIDTH-1:0]              i_gradient,
    input  logic signed [DATA_WIDTH-1:0]              i_momentum,
    input  lion_pkg::t_cfg                            i_cfg,
    output logic                                      o_valid,
    output logic signed [DATA_WIDTH-1:0]              o_weight,
    output logic signed [DATA_WIDTH-1:0]              o_momentum,
    output logic signed [DATA_WIDTH+lion_pkg::WD_W:0] o_wdp,
    output logic                                      o_pos,
    output logic                                      o_neg
);

    localparam int BSW = lion_pkg::BETA_W + 1;
    localparam int PRW = DATA_WIDTH + BSW;
    localparam int SMW = PRW + 1;
    localparam int WPW = DATA_WIDTH + lion_pkg::WD_W + 1;
    localparam logic signed [BSW-1:0] ONE_B = BSW'(lion_pkg::BETA_ONE);
    localparam logic signed [SMW-1:0] HALF  = SMW'(1) <<< (lion_pkg::BETA_FRAC - 1);

    logic signed [BSW-1:0]        w_b1;
    logic signed [BSW-1:0]        w_b2;
    logic signed [BSW-1:0]        w_c1;
    logic signed [BSW-1:0]        w_c2;
    logic signed [lion_pkg::WD_W:0] w_wd;
    logic signed [SMW-1:0]        w_csum;
    logic signed [SMW-1:0]        w_msum;

    logic                         r_v1;
    logic signed [DATA_WIDTH-1:0] r_p1;
    logic signed [PRW-1:0]        r_b1m;
    logic signed [PRW-1:0]        r_c1g;
    logic signed [PRW-1:0]        r_b2m;
    logic signed [PRW-1:0]        r_c2g;
    logic signed [WPW-1:0]        r_wdp1;
    logic signed [PRW-1:0]        n_b1m;
    logic signed [PRW-1:0]        n_c1g;
    logic signed [PRW-1:0]        n_b2m;
    logic signed [PRW-1:0]        n_c2g;
    logic signed [WPW-1:0]        n_wdp1;

    logic                         r_v2;
    logic signed [DATA_WIDTH-1:0] r_p2;
    logic signed [DATA_WIDTH-1:0] r_mo2;
    logic signed [WPW-1:0]        r_wdp2;
    logic                         r_pos2;
    logic                         r_neg2;
    logic signed [DATA_WIDTH-1:0] n_mo2;
    logic                         n_pos2;
    logic                         n_neg2;

    assign w_b1 = $signed({1'b0, lion_pkg::clamp_beta(i_cfg.first_beta)});
    assign w_b2 = $signed({1'b0, lion_pkg::clamp_beta(i_cfg.second_beta)});
    assign w_c1 = ONE_B - w_b1;
    assign w_c2 = ONE_B - w_b2;
    assign w_wd = $signed({1'b0, i_cfg.decay_rate});

    always_comb begin
        n_b1m  = PRW'(i_momentum) * PRW'(w_b1);
        n_c1g  = PRW'(i_gradient) * PRW'(w_c1);
        n_b2m  = PRW'(i_momentum) * PRW'(w_b2);
        n_c2g  = PRW'(i_gradient) * PRW'(w_c2);
        n_wdp1 = WPW'(i_weight) * WPW'(w_wd);
    end

    assign w_csum = SMW'(r_b1m) + SMW'(r_c1g);
    assign w_msum = SMW'(r_b2m) + SMW'(r_c2g) + HALF;

    always_comb begin
        n_pos2 = !w_csum[SMW-1] && (w_csum != '0);
        n_neg2 = w_csum[SMW-1];
        n_mo2  = w_msum[lion_pkg::BETA_FRAC +: DATA_WIDTH];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p1   <= i_weight;
        r_b1m  <= n_b1m;
        r_c1g  <= n_c1g;
        r_b2m  <= n_b2m;
        r_c2g  <= n_c2g;
        r_wdp1 <= n_wdp1;
        r_p2   <= r_p1;
        r_mo2  <= n_mo2;
        r_wdp2 <= r_wdp1;
        r_pos2 <= n_pos2;
        r_neg2 <= n_neg2;
    end

    assign o_valid    = r_v2;
    assign o_weight   = r_p2;
    assign o_momentum = r_mo2;
    assign o_wdp      = r_wdp2;
    assign o_pos      = r_pos2;
    assign o_neg      = r_neg2;

endmodule

>>> rtl/lion_step.sv
module lion_step #(
    parameter int DATA_WIDTH = lion_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = lion_pkg::FRAC_BITS_DEF
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_valid,
    input  logic signed [DATA_WIDTH-1:0]              i_weight,
    input  logic signed [DATA_WIDTH-1:0]              i_momentum,
    input  logic signed [DATA_WIDTH+lion_pkg::WD_W:0] i_wdp,
    input  logic                                      i_pos,
    input  logic                                      i_neg,
    input  logic [lion_pkg::LR_W-1:0]                 i_lr,
    output logic                                      o_valid,
    output logic signed [DATA_WIDTH-1:0]              o_weight_out,
    output logic signed [DATA_WIDTH-1:0]              o_momentum_out,
    output logic                                      o_saturated
);

    localparam int LRW  = lion_pkg::LR_W;
    localparam int WPW  = DATA_WIDTH + lion_pkg::WD_W + 1;
    localparam int SGW  = FRAC_BITS + lion_pkg::BETA_FRAC + 2;
    localparam int UW   = ((WPW > SGW) ? WPW : SGW) + 1;
    localparam int UHW  = UW - LRW;
    localparam int AW   = UHW + LRW + 1;
    localparam int BW   = 2 * LRW;
    localparam int DFW  = BW + 2;
    localparam int QW   = DFW - LRW;
    localparam int QAW  = AW + 1;
    localparam int DW   = QAW - lion_pkg::BETA_FRAC;
    localparam int SUMW = DW + 1;
    localparam logic signed [UW-1:0]  ONE_U = UW'(1) <<< (FRAC_BITS + lion_pkg::BETA_FRAC);
    localparam logic signed [DFW-1:0] HALF_D = DFW'(1) <<< (LRW + lion_pkg::BETA_FRAC - 1);

    logic signed [UW-1:0]         w_u;
    logic signed [SUMW-1:0]       w_sum;
    logic                         w_ovf;

    logic                         r_v3;
    logic signed [DATA_WIDTH-1:0] r_p3;
    logic signed [DATA_WIDTH-1:0] r_mo3;
    logic signed [UHW-1:0]        r_uh3;
    logic [LRW-1:0]               r_ul3;

    logic                         r_v4;
    logic signed [DATA_WIDTH-1:0] r_p4;
    logic signed [DATA_WIDTH-1:0] r_mo4;
    logic signed [AW-1:0]         r_a4;
    logic [BW-1:0]                r_b4;
    logic signed [AW-1:0]         n_a4;
    logic [BW-1:0]                n_b4;

    logic                         r_v5;
    logic signed [DATA_WIDTH-1:0] r_p5;
    logic signed [DATA_WIDTH-1:0] r_mo5;
    logic signed [AW-1:0]         r_a5;
    logic signed [QW-1:0]         r_q5;
    logic signed [DFW-1:0]        n_diff5;

    logic                         r_v6;
    logic signed [DATA_WIDTH-1:0] r_p6;
    logic signed [DATA_WIDTH-1:0] r_mo6;
    logic signed [DW-1:0]         r_d6;
    logic signed [QAW-1:0]        n_qa6;

    logic                         r_v7;
    logic signed [DATA_WIDTH-1:0] r_pn7;
    logic signed [DATA_WIDTH-1:0] r_mo7;
    logic                         r_sat7;
    logic signed [DATA_WIDTH-1:0] n_pn7;

    always_comb begin
        w_u = UW'(i_wdp);
        if (i_pos) begin
            w_u = w_u + ONE_U;
        end else if (i_neg) begin
            w_u = w_u - ONE_U;
        end
    end

    always_comb begin
        n_a4    = AW'(r_uh3) * AW'($signed({1'b0, i_lr}));
        n_b4    = BW'(r_ul3) * BW'(i_lr);
        n_diff5 = HALF_D - $signed({2'b00, r_b4});
        n_qa6   = QAW'(r_q5) - QAW'(r_a5);
    end

    assign w_sum = SUMW'(r_p6) + SUMW'(r_d6);
    assign w_ovf = (w_sum[SUMW-1:DATA_WIDTH-1] != {(SUMW - DATA_WIDTH + 1){1'b0}})
                && (w_sum[SUMW-1:DATA_WIDTH-1] != {(SUMW - DATA_WIDTH + 1){1'b1}});

    always_comb begin
        n_pn7 = w_sum[DATA_WIDTH-1:0];
        if (w_ovf) begin
            n_pn7 = {w_sum[SUMW-1], {(DATA_WIDTH - 1){!w_sum[SUMW-1]}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
            r_v7 <= 1'b0;
        end else begin
            r_v3 <= i_valid;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
            r_v7 <= r_v6;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p3   <= i_weight;
        r_mo3  <= i_momentum;
        r_uh3  <= w_u[UW-1:LRW];
        r_ul3  <= w_u[LRW-1:0];
        r_p4   <= r_p3;
        r_mo4  <= r_mo3;
        r_a4   <= n_a4;
        r_b4   <= n_b4;
        r_p5   <= r_p4;
        r_mo5  <= r_mo4;
        r_a5   <= r_a4;
        r_q5   <= n_diff5[DFW-1:LRW];
        r_p6   <= r_p5;
        r_mo6  <= r_mo5;
        r_d6   <= n_qa6[QAW-1:lion_pkg::BETA_FRAC];
        r_pn7  <= n_pn7;
        r_mo7  <= r_mo6;
        r_sat7 <= w_ovf;
    end

    assign o_valid        = r_v7;
    assign o_weight_out   = r_pn7;
    assign o_momentum_out = r_mo7;
    assign o_saturated    = r_sat7;

endmodule
